// File: hdl/mrt_pkg.sv
package mrt_pkg;

   localparam int REGION_SLOTS_DEF = 16;

   localparam logic [31:0] PAGE_MASK  = 32'hFFFF_F000;
   localparam logic [32:0] PAGE_ROUND = 33'h0_0000_0FFF;
   localparam logic [12:0] PAGE_BYTES = 13'd4096;
   localparam logic [20:0] RSS_MAX    = 21'h1F_FFFF;

   localparam logic [31:0] REGION_BASE_RESET  = 32'h4000_0000;
   localparam logic [31:0] REGION_LIMIT_RESET = 32'hC000_0000;
   localparam logic [20:0] RSS_LIMIT_RESET    = 21'd0;
   localparam logic        USER_TASK_RESET    = 1'b1;

   typedef enum logic [1:0] {
      MODE_REGISTER,
      MODE_UNREGISTER,
      MODE_FAULT,
      MODE_RESERVED
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE,
      STATUS_FAILED,
      STATUS_SEGV
   } status_type;

   typedef enum logic [1:0] {
      CSR_REGION_BASE,
      CSR_REGION_LIMIT,
      CSR_RSS_LIMIT,
      CSR_USER_TASK
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_CHECK,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one slot of the region table as held in memory
   typedef struct packed {
      logic [31:0] start_addr;
      logic [31:0] end_addr;
      logic [7:0]  file;
      logic [31:0] file_start;
      logic [31:0] file_size;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // datapath events seen by the sequencer
   typedef struct packed {
      logic accept;
      logic pre_fail;
      logic scan_done;
      logic out_free;
   } evt_type;

   // sequencer controls to the datapath
   typedef struct packed {
      logic req_ready;
      logic calc;
      logic check;
      logic scan;
      logic commit;
   } ctl_type;

endpackage

// File: hdl/mrt_ram.sv
module mrt_ram
   #(parameter int WIDTH  = 8,
     parameter int DEPTH  = 16,
     parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic              clock,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mrt_fsm.sv
module mrt_fsm
   import mrt_pkg::*;
   (input  logic    clock,
    input  logic    reset,
    input  evt_type evt,
    output ctl_type ctl);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (evt.accept) state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = evt.pre_fail ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            if (evt.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (evt.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_IDLE:   ctl.req_ready = 1'b1;
         ST_CALC:   ctl.calc      = 1'b1;
         ST_CHECK:  ctl.check     = 1'b1;
         ST_SCAN:   ctl.scan      = 1'b1;
         ST_FINISH: ctl.commit    = evt.out_free;
         default:   ctl = '0;
      endcase
   end

endmodule

// File: hdl/mapped_region_table.sv
// Mapped region table: up to REGION_SLOTS file-backed virtual regions.
//
// Request channel (req_*): valid/ready. req_mode selects register (0),
// unregister (1) or page fault (2). req_ready is high only while the
// table is idle; one transaction is worked on at a time.
// Response channel (rsp_*): valid/ready, exactly one response per request.
// Config port (csr_*): write enable, index, data; written only when idle by the user, which the block does not check.
//
// Sequence: accept, form the aligned end address, run the early checks,
// then scan the slot memory at one slot per cycle, each slot compared the
// cycle after its registered read, then commit. A request that fails its
// early checks skips the scan; a full scan reads every slot in turn, as
// the single-read slot memory gives one read at a time.
// The response sits in an output register: a new request is taken while
// it waits; if the receiver stalls, the next commit waits for it.
// Reset: all slots free, next free address = region_base, resident count
// zero, config registers at their defaults. No memory clearing is needed.
module mapped_region_table
   import mrt_pkg::*;
   #(parameter int REGION_SLOTS = REGION_SLOTS_DEF)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_mode,
    input  logic [31:0] req_address,
    input  logic [31:0] req_length,
    input  logic [7:0]  req_file_index,
    input  logic [31:0] req_file_base,
    input  logic        req_protection_fault,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  rsp_status,
    output logic [31:0] rsp_region_address,
    output logic [20:0] rsp_page_count,
    output logic [7:0]  rsp_fill_file,
    output logic [31:0] rsp_fill_offset,
    output logic [12:0] rsp_fill_length,
    input  logic        csr_we,
    input  logic [1:0]  csr_index,
    input  logic [31:0] csr_wdata);

   localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int CNT_W = $clog2(REGION_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(REGION_SLOTS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REGION_SLOTS - 1);

   evt_type evt;
   ctl_type ctl;

   // configuration
   logic [31:0] limit_ff;
   logic [20:0] rss_limit_ff;
   logic        user_ff;

   // table state outside the memory
   logic [REGION_SLOTS-1:0] valid_ff, valid_in;
   logic [31:0]             next_free_ff, next_free_in;
   logic [20:0]             resident_ff, resident_in;

   // latched transaction
   mode_type    mode_ff;
   logic [31:0] addr_ff, len_ff, foff_ff;
   logic [7:0]  file_ff;
   logic        prot_ff;
   logic [32:0] aligned_ff;
   logic [33:0] sum_ff;

   // scan
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             rd_en;
   logic [ENTRY_W-1:0] rd_data;
   entry_type        rd_entry;
   logic             slot_vld, match;

   // hit capture
   logic             fail_ff, fail_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [31:0]      diff_ff;
   logic [7:0]       hit_file_ff;
   logic [31:0]      hit_fstart_ff, hit_fsize_ff;

   // result
   logic        pre_fail;
   logic [31:0] page;
   logic        cap_hit, in_file;
   logic [32:0] fsum;
   logic [31:0] remain;
   logic [12:0] take;
   status_type  res_status;
   logic [31:0] res_addr, res_off;
   logic [20:0] res_count;
   logic [7:0]  res_file;
   logic [12:0] res_len;
   logic        do_reg, do_unreg, do_fault;
   logic        wr_en;
   entry_type   wr_entry;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic [31:0] rsp_addr_ff, rsp_off_ff;
   logic [20:0] rsp_count_ff;
   logic [7:0]  rsp_file_ff;
   logic [12:0] rsp_len_ff;

   mrt_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .evt   (evt),
      .ctl   (ctl));

   mrt_ram #(.WIDTH(ENTRY_W), .DEPTH(REGION_SLOTS), .ADDR_W(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (hit_idx_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data));

   assign req_ready = ctl.req_ready;
   assign page      = addr_ff & PAGE_MASK;

   // early checks
   always_comb begin
      case (mode_ff)
         MODE_REGISTER:   pre_fail = (len_ff == 32'd0) || (sum_ff > {2'b00, limit_ff});
         MODE_UNREGISTER: pre_fail = 1'b0;
         MODE_FAULT:      pre_fail = !user_ff || prot_ff;
         default:         pre_fail = 1'b1;
      endcase
   end

   // slot scan: read issued one cycle, compared the next
   assign rd_entry = entry_type'(rd_data);
   assign slot_vld = valid_ff[pend_idx_ff];

   always_comb begin
      case (mode_ff)
         MODE_REGISTER:   match = !slot_vld;
         MODE_UNREGISTER: match = slot_vld && (rd_entry.start_addr == addr_ff)
                                  && (sum_ff == {2'b00, rd_entry.end_addr});
         MODE_FAULT:      match = slot_vld && (addr_ff >= rd_entry.start_addr)
                                  && (addr_ff < rd_entry.end_addr);
         default:         match = 1'b0;
      endcase
   end

   always_comb begin
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      rd_en       = 1'b0;
      if (ctl.check) begin
         issue_in = '0;
      end else if (ctl.scan && (issue_ff != CNT_END)) begin
         rd_en       = 1'b1;
         issue_in    = issue_ff + CNT_W'(1);
         pend_in     = 1'b1;
         pend_idx_in = issue_ff[IDX_W-1:0];
      end
   end

   assign evt.accept    = req_valid && ctl.req_ready;
   assign evt.pre_fail  = pre_fail;
   assign evt.scan_done = pend_ff && (match || (pend_idx_ff == IDX_LAST));
   assign evt.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      fail_in = fail_ff;
      hit_in  = hit_ff;
      if (ctl.check) begin
         fail_in = pre_fail;
         hit_in  = 1'b0;
      end else if (ctl.scan && evt.scan_done) begin
         hit_in = match;
      end
   end

   // fault file slice
   assign cap_hit = (rss_limit_ff != 21'd0) && (resident_ff >= rss_limit_ff);
   assign in_file = diff_ff < hit_fsize_ff;
   assign fsum    = {1'b0, hit_fstart_ff} + {1'b0, diff_ff};
   assign remain  = hit_fsize_ff - diff_ff;
   assign take    = (remain > {19'd0, PAGE_BYTES}) ? PAGE_BYTES : remain[12:0];

   always_comb begin
      res_status = STATUS_FAILED;
      res_addr   = '0;
      res_count  = '0;
      res_file   = '0;
      res_off    = '0;
      res_len    = '0;
      do_reg     = 1'b0;
      do_unreg   = 1'b0;
      do_fault   = 1'b0;
      if (!fail_ff && hit_ff) begin
         case (mode_ff)
            MODE_REGISTER: begin
               res_status = STATUS_DONE;
               res_addr   = next_free_ff;
               do_reg     = 1'b1;
            end
            MODE_UNREGISTER: begin
               res_status = STATUS_DONE;
               res_addr   = addr_ff;
               res_count  = {1'b0, diff_ff[31:12]};
               do_unreg   = 1'b1;
            end
            MODE_FAULT: begin
               res_addr = page;
               if (cap_hit) begin
                  res_status = STATUS_SEGV;
               end else begin
                  res_status = STATUS_DONE;
                  res_file   = hit_file_ff;
                  do_fault   = 1'b1;
                  if (in_file && !fsum[32]) begin
                     res_off = fsum[31:0];
                     res_len = take;
                  end
               end
            end
            default: begin
               res_status = STATUS_FAILED;
            end
         endcase
      end
   end

   assign wr_en    = ctl.commit && do_reg;
   assign wr_entry = '{start_addr: next_free_ff, end_addr: sum_ff[31:0], file: file_ff,
                       file_start: foff_ff, file_size: len_ff};

   always_comb begin
      valid_in     = valid_ff;
      next_free_in = next_free_ff;
      resident_in  = resident_ff;
      if (ctl.commit) begin
         if (do_reg) begin
            valid_in[hit_idx_ff] = 1'b1;
            next_free_in         = sum_ff[31:0];
         end
         if (do_unreg) valid_in[hit_idx_ff] = 1'b0;
         if (do_fault && (resident_ff != RSS_MAX)) resident_in = resident_ff + 21'd1;
      end
      if (csr_we && (csr_index_type'(csr_index) == CSR_REGION_BASE)) begin
         next_free_in = csr_wdata & PAGE_MASK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (ctl.commit) rsp_valid_in = 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= REGION_LIMIT_RESET;
         rss_limit_ff <= RSS_LIMIT_RESET;
         user_ff      <= USER_TASK_RESET;
         valid_ff     <= '0;
         next_free_ff <= REGION_BASE_RESET & PAGE_MASK;
         resident_ff  <= '0;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         fail_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_REGION_BASE:  ;
               CSR_REGION_LIMIT: limit_ff     <= csr_wdata;
               CSR_RSS_LIMIT:    rss_limit_ff <= csr_wdata[20:0];
               CSR_USER_TASK:    user_ff      <= csr_wdata[0];
               default:          ;
            endcase
         end
         valid_ff     <= valid_in;
         next_free_ff <= next_free_in;
         resident_ff  <= resident_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         fail_ff      <= fail_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      if (evt.accept) begin
         mode_ff    <= mode_type'(req_mode);
         addr_ff    <= req_address;
         len_ff     <= req_length;
         file_ff    <= req_file_index;
         foff_ff    <= req_file_base;
         prot_ff    <= req_protection_fault;
         aligned_ff <= ({1'b0, req_length} + PAGE_ROUND) & ~PAGE_ROUND;
      end
      if (ctl.calc) begin
         sum_ff <= {2'b00, (mode_ff == MODE_REGISTER) ? next_free_ff : addr_ff}
                   + {1'b0, aligned_ff};
      end
      if (ctl.scan && evt.scan_done) begin
         hit_idx_ff    <= pend_idx_ff;
         hit_file_ff   <= rd_entry.file;
         hit_fstart_ff <= rd_entry.file_start;
         hit_fsize_ff  <= rd_entry.file_size;
         diff_ff       <= ((mode_ff == MODE_UNREGISTER) ? rd_entry.end_addr : page)
                          - rd_entry.start_addr;
      end
      if (ctl.commit) begin
         rsp_status_ff <= res_status;
         rsp_addr_ff   <= res_addr;
         rsp_count_ff  <= res_count;
         rsp_file_ff   <= res_file;
         rsp_off_ff    <= res_off;
         rsp_len_ff    <= res_len;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_region_address = rsp_addr_ff;
   assign rsp_page_count     = rsp_count_ff;
   assign rsp_fill_file      = rsp_file_ff;
   assign rsp_fill_offset    = rsp_off_ff;
   assign rsp_fill_length    = rsp_len_ff;

endmodule

// File: hdl/mrt_checker.sv
module mrt_checker
   import mrt_pkg::*;
   (input logic        clock,
    input logic        reset,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [31:0] rsp_region_address,
    input logic [20:0] rsp_page_count,
    input logic [7:0]  rsp_fill_file,
    input logic [31:0] rsp_fill_offset,
    input logic [12:0] rsp_fill_length);

   // a stalled response holds its status, region address and fill offset
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_region_address) && $stable(rsp_fill_offset))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a failed transaction carries nothing else
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FAILED) |-> (rsp_region_address == 32'd0)
         && (rsp_page_count == 21'd0) && (rsp_fill_file == 8'd0)
         && (rsp_fill_offset == 32'd0) && (rsp_fill_length == 13'd0))
      else $error("failed response with nonzero fields");

   // every region and fault address is page aligned
   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region_address[11:0] == 12'd0))
      else $error("unaligned region address");

   a_segv_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_SEGV) |-> (rsp_fill_length == 13'd0)
         && (rsp_fill_offset == 32'd0) && (rsp_page_count == 21'd0))
      else $error("segfault response carries a file slice");

endmodule

bind mapped_region_table mrt_checker u_checker (.*);
